/* rtl/i4dq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package i4dq_pkg;
  localparam int LANES = 8;
  localparam int NUM_OUT = 8;
  localparam logic [15:0] BF_DEFAULT_NAN = 16'h7FC0;
  localparam logic [15:0] BF_INF = 16'h7F80;

  typedef struct packed {
    logic [15:0] group_scale;
    logic [31:0] packed_weights;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] value7;
    logic [15:0] value6;
    logic [15:0] value5;
    logic [15:0] value4;
    logic [15:0] value3;
    logic [15:0] value2;
    logic [15:0] value1;
    logic [15:0] value0;
  } out_beat_t;
endpackage
`default_nettype wire

/* rtl/i4dq_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
module i4dq_lane (
  input  logic [3:0]  weight,
  input  logic [15:0] scale,
  output logic [15:0] value
);
  import i4dq_pkg::*;
  logic        ssign, wneg;
  logic [7:0]  sexp;
  logic [6:0]  sfrac;
  logic [3:0]  mag;
  logic [15:0] rsign;
  logic [10:0] prod;
  logic [1:0]  sh;
  logic [8:0]  q;
  logic [2:0]  rem, half;
  logic [9:0]  e;

  always_comb begin
    ssign = scale[15];
    sexp = scale[14:7];
    sfrac = scale[6:0];
    wneg = weight[3];
    mag = wneg ? (4'd0 - weight) : weight;
    rsign = {ssign ^ wneg, 15'd0};
    prod = {3'b0, 1'b1, sfrac} * {7'd0, mag};
    priority if (prod[10]) sh = 2'd3;
    else if (prod[9]) sh = 2'd2;
    else if (prod[8]) sh = 2'd1;
    else sh = 2'd0;
    q = {1'b0, prod[10:3]};
    rem = 3'd0;
    half = 3'd0;
    unique case (sh)
      2'd0: q = {1'b0, prod[7:0]};
      2'd1: begin q = {1'b0, prod[8:1]}; rem = {2'b0, prod[0]}; half = 3'd1; end
      2'd2: begin q = {1'b0, prod[9:2]}; rem = {1'b0, prod[1:0]}; half = 3'd2; end
      default: begin q = {1'b0, prod[10:3]}; rem = prod[2:0]; half = 3'd4; end
    endcase
    if (sh != 2'd0 && (rem > half || (rem == half && q[0]))) q = q + 9'd1;
    e = {2'b0, sexp} + {8'd0, sh};
    if (q[8]) begin
      q = 9'h080;
      e = e + 10'd1;
    end
    if (sexp == 8'hFF) begin
      if (sfrac != 7'd0) value = scale | 16'h0040;
      else if (mag == 4'd0) value = BF_DEFAULT_NAN;
      else value = rsign | BF_INF;
    end else if (sexp == 8'd0 || mag == 4'd0) value = rsign;
    else if (e >= 10'd255) value = rsign | BF_INF;
    else value = rsign | {1'b0, e[7:0], q[6:0]};
  end
endmodule
`default_nettype wire

/* rtl/int4_group_dequantize_bf16_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Dequantizes eight signed int4 weights by one bfloat16 group scale per beat.
// Eight lanes work in parallel; results are merged into one registered output
// beat, one beat per cycle unless stalled. A skid register holds one beat
// under out_stall; in_stall is its valid. Lanes at or above LANES read zero.
module int4_group_dequantize_bf16_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  i4dq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i4dq_pkg::out_beat_t out_data
);
  import i4dq_pkg::*;
  logic [NUM_OUT-1:0][15:0] lane_val;
  out_beat_t merged;
  out_beat_t out_r, skid_r;
  logic out_vld_r, skid_vld_r;

  for (genvar g = 0; g < NUM_OUT; g++) begin : g_lane
    if (g < LANES) begin : g_on
      i4dq_lane u_lane (
        .weight(in_data.packed_weights[4*g+3:4*g]),
        .scale (in_data.group_scale),
        .value (lane_val[g])
      );
    end else begin : g_off
      assign lane_val[g] = 16'd0;
    end
  end

  assign merged = out_beat_t'(lane_val);
  assign in_stall = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || !out_stall) begin
        if (skid_vld_r) begin
          out_r <= skid_r;
          out_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_r <= merged;
          out_vld_r <= in_valid;
        end
      end else if (in_valid && !skid_vld_r) begin
        skid_r <= merged;
        skid_vld_r <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");
  a_skid: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid full with empty output");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r && !out_stall |=> !skid_vld_r)
    else $error("skid not drained");
`endif
endmodule
`default_nettype wire
